### hw/rtl/first_fit_aligned_free_run_allocator_defines.svh
// ----------------------------------------------------------------------------
// First-fit allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_ALIGNED_FREE_RUN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ALIGNED_FREE_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk and idle during reset.
`define FFA_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, clocked on clk and idle during reset.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

### hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Codes, defaults and types shared by the allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

	// Parameter defaults.
	localparam int MAX_RUNS_DEF  = 64;
	localparam int ADDR_BITS_DEF = 32;

	// Region length after reset.
	localparam logic [31:0] RESET_REGION = 32'h0200_0000;

	// Request functions.
	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [1:0] FUNC_NONE    = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Register byte addresses.
	localparam logic [1:0] ADDR_REGION = 2'd0;

	// Status of the remainder unit.
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

### hw/rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/ffa_rem.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial remainder of an address by a 32-bit alignment.
// ----------------------------------------------------------------------------
module ffa_rem #(
	parameter int ADDR_BITS = ffa_pkg::ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADDR_BITS-1:0] dividend,
	input  logic [31:0]          divisor,
	output logic [31:0]          rem,
	output ffa_pkg::rem_stat_t   stat
);

	localparam int NW = $clog2(ADDR_BITS + 1);
	localparam logic [NW-1:0] STEPS = NW'(ADDR_BITS);

	logic [ADDR_BITS-1:0] quo_q;
	logic [31:0]          rem_q;
	logic [31:0]          dvs_q;
	logic [NW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic [31:0]          rem_next;

	// One dividend bit per cycle: shift in, subtract when it fits.
	always_comb begin
		trial = {rem_q, quo_q[ADDR_BITS-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = 32'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[31:0];
		end
	end

	// Control: count the steps and pulse done after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= cnt_q != NW'(1);
				done_q <= cnt_q == NW'(1);
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			rem_q <= rem_next;
		end
	end

	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hw/rtl/first_fit_aligned_free_run_allocator.sv
// ----------------------------------------------------------------------------
// First-fit aligned free-run allocator
// Keeps a sorted table of free runs in RAM and serves allocate, release and
// clear requests one at a time with a small sequencer.
// ----------------------------------------------------------------------------
//  Channel  Handshake                   Payload
//  in       in_valid / in_ready         func, req_size, req_alignment, req_offset
//  out      out_valid / out_ready       status, out_offset, free_run_count
//  apb      psel, penable, pready       paddr, pwrite, pwdata, prdata
//
// An allocate reads, latches and checks each run it scans; when the alignment
// is nonzero it also waits in S_A_DIV for the bit-serial remainder unit.
// Opening or closing a table slot moves each entry after it through the table
// RAM, then any new entries are written in S_WR1 and S_WR2 before S_FIN gives
// the result. A release reads and compares each run ahead of its place. After
// reset the block writes the initial run in S_INIT before it takes a request.
// A stalled result holds in the output register; the next request is taken
// once the result has been loaded there.
// ----------------------------------------------------------------------------
`include "first_fit_aligned_free_run_allocator_defines.svh"

module first_fit_aligned_free_run_allocator #(
	parameter int MAX_RUNS  = ffa_pkg::MAX_RUNS_DEF,
	parameter int ADDR_BITS = ffa_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] req_size,
	input  logic [31:0] req_alignment,
	input  logic [31:0] req_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_offset,
	output logic [6:0]  free_run_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = ADDR_BITS;
	localparam int CW = $clog2(MAX_RUNS + 1);
	localparam int IW = $clog2(MAX_RUNS);
	localparam int WW = ((AW > 32) ? AW : 32) + 1;
	localparam int DW = 2 * AW;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RUNS);
	localparam logic [AW-1:0] ADDR_MAX = '1;
	localparam logic [AW-1:0] RESET_LEN =
		(64'(ffa_pkg::RESET_REGION) > ((64'd1 << AW) - 64'd1)) ? ADDR_MAX :
		AW'(ffa_pkg::RESET_REGION);

	// Sequencer states.
	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_A_RD  = 4'd2;
	localparam logic [3:0] S_A_LAT = 4'd3;
	localparam logic [3:0] S_A_DIV = 4'd4;
	localparam logic [3:0] S_A_CHK = 4'd5;
	localparam logic [3:0] S_R_RD  = 4'd6;
	localparam logic [3:0] S_R_LAT = 4'd7;
	localparam logic [3:0] S_R_DEC = 4'd8;
	localparam logic [3:0] S_MOVE  = 4'd9;
	localparam logic [3:0] S_WR1   = 4'd10;
	localparam logic [3:0] S_WR2   = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;

	logic [3:0]    state_q;
	logic [31:0]   region_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   size_q;
	logic [31:0]   align_q;
	logic [AW-1:0] off_q;
	logic [AW-1:0] rsize_q;
	logic [AW-1:0] cur_s_q;
	logic [AW-1:0] cur_l_q;
	logic [AW-1:0] prev_s_q;
	logic [AW-1:0] prev_l_q;
	logic [WW-1:0] at_q;
	logic          has_next_q;
	logic [1:0]    st_q;
	logic [AW-1:0] got_q;
	logic [CW-1:0] mv_rd_q;
	logic [CW-1:0] mv_wr_q;
	logic [CW-1:0] mv_n_q;
	logic          mv_up_q;
	logic          mv_wv_q;
	logic          w1_v_q;
	logic [IW-1:0] w1_a_q;
	logic [DW-1:0] w1_d_q;
	logic          w2_v_q;
	logic [IW-1:0] w2_a_q;
	logic [DW-1:0] w2_d_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   offset_q;
	logic [6:0]    count_q;

	logic          ram_we;
	logic [IW-1:0] ram_wa;
	logic [DW-1:0] ram_wd;
	logic          ram_re;
	logic [IW-1:0] ram_ra;
	logic [DW-1:0] ram_rd;
	logic [AW-1:0] rd_s;
	logic [AW-1:0] rd_l;
	logic          wr_state;

	logic               rem_start;
	logic [31:0]        rem_val;
	ffa_pkg::rem_stat_t rem_stat;

	logic [AW+31:0] in_off_ext;
	logic [AW+31:0] in_sz_ext;
	logic [AW-1:0]  in_off;
	logic [AW-1:0]  in_room;
	logic [AW-1:0]  in_rsize;
	logic [AW+31:0] reg_ext;
	logic [AW-1:0]  clr_len;
	logic [WW-1:0]  s_w;
	logic [WW-1:0]  end_w;
	logic [AW-1:0]  end_a;
	logic [WW-1:0]  size_w;
	logic [WW-1:0]  align_w;
	logic [WW-1:0]  rem_w;
	logic [WW-1:0]  aligned_up;
	logic           fit;
	logic [WW-1:0]  asz_w;
	logic           has_tail;
	logic [WW-1:0]  tail_w;
	logic [WW-1:0]  pad_w;
	logic [AW-1:0]  new_end;
	logic           merge_next;
	logic           merge_prev;
	logic [CW-1:0]  idx_m1;
	logic [CW-1:0]  idx_p1;
	logic [CW+6:0]  cnt_ext;
	logic [AW+31:0] got_ext;
	logic           out_load;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr == ffa_pkg::ADDR_REGION) ? region_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= ffa_pkg::RESET_REGION;
		end else if (psel && penable && pwrite && (paddr == ffa_pkg::ADDR_REGION)) begin
			region_q <= pwdata;
		end
	end

	// Free-run table: {start, length} per entry.
	ffa_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_RUNS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.re   (ram_re),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	assign rd_s = ram_rd[DW-1:AW];
	assign rd_l = ram_rd[AW-1:0];

	// Remainder unit for the alignment round-up.
	assign rem_start = (state_q == S_A_LAT) && (align_q != 32'd0);

	ffa_rem #(
		.ADDR_BITS(AW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(rd_s),
		.divisor (align_q),
		.rem     (rem_val),
		.stat    (rem_stat)
	);

	// Request clipping at accept time.
	always_comb begin
		in_off_ext = {{AW{1'b0}}, req_offset};
		in_off     = in_off_ext[AW-1:0];
		in_room    = ADDR_MAX - in_off;
		in_sz_ext  = {{AW{1'b0}}, req_size};
		if (in_sz_ext > {32'd0, in_room}) begin
			in_rsize = in_room;
		end else begin
			in_rsize = in_sz_ext[AW-1:0];
		end
		reg_ext = {{AW{1'b0}}, region_q};
		if (reg_ext > {32'd0, ADDR_MAX}) begin
			clr_len = ADDR_MAX;
		end else begin
			clr_len = reg_ext[AW-1:0];
		end
	end

	// Allocation arithmetic on the current run.
	always_comb begin
		s_w        = {{(WW-AW){1'b0}}, cur_s_q};
		end_a      = cur_s_q + cur_l_q;
		end_w      = {{(WW-AW){1'b0}}, end_a};
		size_w     = {{(WW-32){1'b0}}, size_q};
		align_w    = {{(WW-32){1'b0}}, align_q};
		rem_w      = {{(WW-32){1'b0}}, rem_val};
		aligned_up = (rem_val == 32'd0) ? s_w : (s_w + align_w - rem_w);
		fit        = !(at_q > end_w) && !((end_w - at_q) < size_w);
		asz_w      = at_q + size_w;
		has_tail   = asz_w < end_w;
		tail_w     = end_w - asz_w;
		pad_w      = at_q - s_w;
	end

	// Release neighbor checks.
	assign new_end    = off_q + rsize_q;
	assign merge_next = has_next_q && (new_end == cur_s_q);
	assign merge_prev = (idx_q != '0) && ((prev_s_q + prev_l_q) == off_q);
	assign idx_m1     = idx_q - 1'b1;
	assign idx_p1     = idx_q + 1'b1;

	// RAM port control.
	always_comb begin
		ram_re = 1'b0;
		ram_ra = idx_q[IW-1:0];
		ram_we = 1'b0;
		ram_wa = w1_a_q;
		ram_wd = w1_d_q;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_wa = '0;
				ram_wd = {{AW{1'b0}}, RESET_LEN};
			end
			S_A_RD: begin
				ram_re = idx_q < total_q;
			end
			S_R_RD: begin
				ram_re = idx_q != total_q;
			end
			S_MOVE: begin
				ram_re = mv_n_q != '0;
				ram_ra = mv_rd_q[IW-1:0];
				ram_we = mv_wv_q;
				ram_wa = mv_wr_q[IW-1:0];
				ram_wd = ram_rd;
			end
			S_WR1: begin
				ram_we = 1'b1;
			end
			S_WR2: begin
				ram_we = 1'b1;
				ram_wa = w2_a_q;
				ram_wd = w2_d_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// States that may write the table.
	assign wr_state = (state_q == S_MOVE) || (state_q == S_WR1) || (state_q == S_WR2) ||
		(state_q == S_INIT);

	assign in_ready = state_q == S_IDLE;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			total_q <= CW'(1);
			idx_q   <= '0;
			mv_n_q  <= '0;
			mv_wv_q <= 1'b0;
			w1_v_q  <= 1'b0;
			w2_v_q  <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						idx_q  <= '0;
						w2_v_q <= 1'b0;
						case (func)
							ffa_pkg::FUNC_ALLOC: begin
								state_q <= S_A_RD;
							end
							ffa_pkg::FUNC_RELEASE: begin
								if (in_rsize == '0 || total_q >= CNT_MAX) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_R_RD;
								end
							end
							ffa_pkg::FUNC_CLEAR: begin
								w1_v_q  <= 1'b1;
								total_q <= (clr_len != '0) ? CW'(1) : '0;
								state_q <= S_WR1;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_A_RD: begin
					state_q <= (idx_q < total_q) ? S_A_LAT : S_FIN;
				end
				S_A_LAT: begin
					state_q <= (align_q != 32'd0) ? S_A_DIV : S_A_CHK;
				end
				S_A_DIV: begin
					if (rem_stat.done) begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if (!fit) begin
						idx_q   <= idx_p1;
						state_q <= S_A_RD;
					end else if (at_q != s_w) begin
						if (has_tail) begin
							if (total_q >= CNT_MAX) begin
								state_q <= S_FIN;
							end else begin
								// Open slot i+1 for the tail, then trim run i.
								mv_up_q <= 1'b1;
								mv_rd_q <= total_q - 1'b1;
								mv_wr_q <= total_q;
								mv_n_q  <= total_q - idx_p1;
								total_q <= total_q + 1'b1;
								w1_v_q  <= 1'b1;
								w2_v_q  <= 1'b1;
								state_q <= S_MOVE;
							end
						end else begin
							w1_v_q  <= 1'b1;
							state_q <= S_WR1;
						end
					end else if (has_tail) begin
						w1_v_q  <= 1'b1;
						state_q <= S_WR1;
					end else begin
						// Run used up exactly: close slot i.
						mv_up_q <= 1'b0;
						mv_rd_q <= idx_p1;
						mv_wr_q <= idx_q;
						mv_n_q  <= total_q - idx_p1;
						total_q <= total_q - 1'b1;
						w1_v_q  <= 1'b0;
						state_q <= S_MOVE;
					end
				end
				S_R_RD: begin
					state_q <= (idx_q != total_q) ? S_R_LAT : S_R_DEC;
				end
				S_R_LAT: begin
					if (rd_s < off_q) begin
						idx_q   <= idx_p1;
						state_q <= S_R_RD;
					end else begin
						state_q <= S_R_DEC;
					end
				end
				S_R_DEC: begin
					w1_v_q <= 1'b1;
					if (!merge_next && !merge_prev) begin
						mv_up_q <= 1'b1;
						mv_rd_q <= total_q - 1'b1;
						mv_wr_q <= total_q;
						mv_n_q  <= total_q - idx_q;
						total_q <= total_q + 1'b1;
						state_q <= S_MOVE;
					end else if (merge_next && merge_prev) begin
						mv_up_q <= 1'b0;
						mv_rd_q <= idx_p1;
						mv_wr_q <= idx_q;
						mv_n_q  <= total_q - idx_p1;
						total_q <= total_q - 1'b1;
						state_q <= S_MOVE;
					end else begin
						state_q <= S_WR1;
					end
				end
				S_MOVE: begin
					if (mv_n_q != '0) begin
						mv_rd_q <= mv_up_q ? (mv_rd_q - 1'b1) : (mv_rd_q + 1'b1);
						mv_n_q  <= mv_n_q - 1'b1;
					end
					mv_wv_q <= mv_n_q != '0;
					if (mv_wv_q) begin
						mv_wr_q <= mv_up_q ? (mv_wr_q - 1'b1) : (mv_wr_q + 1'b1);
					end
					if (mv_n_q == '0 && !mv_wv_q) begin
						state_q <= w1_v_q ? S_WR1 : S_FIN;
					end
				end
				S_WR1: begin
					state_q <= w2_v_q ? S_WR2 : S_FIN;
				end
				S_WR2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				size_q  <= req_size;
				align_q <= req_alignment;
				off_q   <= in_off;
				rsize_q <= in_rsize;
				got_q   <= '0;
				st_q    <= (func == ffa_pkg::FUNC_RELEASE && in_rsize != '0 &&
					total_q >= CNT_MAX) ? ffa_pkg::ST_FULL : ffa_pkg::ST_OK;
				w1_a_q  <= '0;
				w1_d_q  <= {{AW{1'b0}}, clr_len};
			end
			S_A_RD: begin
				if (!(idx_q < total_q)) begin
					st_q <= ffa_pkg::ST_NOFIT;
				end
			end
			S_A_LAT: begin
				cur_s_q <= rd_s;
				cur_l_q <= rd_l;
				at_q    <= {{(WW-AW){1'b0}}, rd_s};
			end
			S_A_DIV: begin
				if (rem_stat.done) begin
					at_q <= aligned_up;
				end
			end
			S_A_CHK: begin
				if (fit) begin
					if (at_q != s_w) begin
						if (has_tail) begin
							if (total_q >= CNT_MAX) begin
								st_q  <= ffa_pkg::ST_FULL;
								got_q <= '0;
							end else begin
								got_q <= at_q[AW-1:0];
							end
							w1_a_q <= idx_p1[IW-1:0];
							w1_d_q <= {asz_w[AW-1:0], tail_w[AW-1:0]};
							w2_a_q <= idx_q[IW-1:0];
							w2_d_q <= {cur_s_q, pad_w[AW-1:0]};
						end else begin
							got_q  <= at_q[AW-1:0];
							w1_a_q <= idx_q[IW-1:0];
							w1_d_q <= {cur_s_q, pad_w[AW-1:0]};
						end
					end else begin
						got_q  <= at_q[AW-1:0];
						w1_a_q <= idx_q[IW-1:0];
						w1_d_q <= {asz_w[AW-1:0], tail_w[AW-1:0]};
					end
				end
			end
			S_R_LAT: begin
				if (rd_s < off_q) begin
					prev_s_q <= rd_s;
					prev_l_q <= rd_l;
				end else begin
					cur_s_q <= rd_s;
					cur_l_q <= rd_l;
				end
			end
			S_R_DEC: begin
				if (merge_prev) begin
					w1_a_q <= idx_m1[IW-1:0];
					w1_d_q <= {prev_s_q,
						prev_l_q + rsize_q + (merge_next ? cur_l_q : {AW{1'b0}})};
				end else begin
					w1_a_q <= idx_q[IW-1:0];
					w1_d_q <= {off_q, rsize_q + (merge_next ? cur_l_q : {AW{1'b0}})};
				end
			end
			default: begin
				st_q <= st_q;
			end
		endcase
	end

	// The next-run flag is set only when the search stops on a held run.
	always_ff @(posedge clk) begin
		if (state_q == S_R_RD) begin
			has_next_q <= 1'b0;
		end else if (state_q == S_R_LAT && !(rd_s < off_q)) begin
			has_next_q <= 1'b1;
		end
	end

	// Output register.
	assign cnt_ext = {7'd0, total_q};
	assign got_ext = {32'd0, got_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= st_q;
			offset_q <= got_ext[31:0];
			count_q  <= cnt_ext[6:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_offset     = offset_q;
	assign free_run_count = count_q;

	// Checks.
	`FFA_ASSERT_IMPLY(a_total_bound, 1'b1, total_q <= CNT_MAX)
	`FFA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
	`FFA_ASSERT_IMPLY(a_we_state, ram_we, wr_state)
	`FFA_ASSERT_IMPLY(a_out_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN)
	`FFA_ASSERT_IMPLY(a_div_done, rem_stat.done, state_q == S_A_DIV)

endmodule

### tb/tb_first_fit_aligned_free_run_allocator.sv
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Drives allocate, release and clear requests into the allocator and checks
// every result against a predictor that keeps its own copy of the run table.
// Idle gaps appear on both channels, and a long result stall fills the block.
// ----------------------------------------------------------------------------
module tb_first_fit_aligned_free_run_allocator;

	localparam int RUNS = ffa_pkg::MAX_RUNS_DEF;
	localparam longint unsigned LIMIT_ADDR = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] off;
		logic [6:0]  cnt;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = ffa_pkg::FUNC_ALLOC;
	logic [31:0] req_size = '0;
	logic [31:0] req_alignment = '0;
	logic [31:0] req_offset = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] out_offset;
	logic [6:0]  free_run_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = ffa_pkg::ADDR_REGION;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: the free-run table and the region length.
	longint unsigned free_start[RUNS];
	longint unsigned free_len[RUNS];
	int              free_total;
	longint unsigned region_len;

	alloc_result_t pending_results[$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  gaps_on = 1'b1;
	bit  hold_out = 1'b0;

	always #2 clk = ~clk;

	first_fit_aligned_free_run_allocator dut (.*);

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 20000000) begin
			$display("FAIL first_fit_aligned_free_run_allocator");
			$finish;
		end
	end

	// Receiver side: random stalls, plus a long hold when requested.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker compares each result with the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result st=%0d off=%h cnt=%0d", status,
						out_offset, free_run_count);
			end else begin
				want = pending_results.pop_front();
				if (want.st !== status || want.off !== out_offset ||
						want.cnt !== free_run_count) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("exp st=%0d off=%h cnt=%0d got st=%0d off=%h cnt=%0d",
							want.st, want.off, want.cnt, status, out_offset,
							free_run_count);
				end
			end
		end
	end

	function automatic longint unsigned align_up(longint unsigned v, longint unsigned a);
		if (a == 0)
			return v;
		return (v + a - 1) / a * a;
	endfunction

	function automatic void shift_open(int i);
		for (int k = free_total; k > i; k--) begin
			free_start[k] = free_start[k - 1];
			free_len[k] = free_len[k - 1];
		end
		free_total++;
	endfunction

	function automatic void shift_close(int i);
		for (int k = i; k + 1 < free_total; k++) begin
			free_start[k] = free_start[k + 1];
			free_len[k] = free_len[k + 1];
		end
		free_total--;
	endfunction

	function automatic void rebuild_table();
		longint unsigned len;
		len = (region_len < LIMIT_ADDR) ? region_len : LIMIT_ADDR;
		free_start[0] = 0;
		free_len[0] = len;
		free_total = (len != 0) ? 1 : 0;
	endfunction

	function automatic logic [1:0] take_run(longint unsigned sz, longint unsigned al,
			output longint unsigned got);
		longint unsigned s, e, at;
		got = 0;
		for (int i = 0; i < free_total; i++) begin
			s = free_start[i];
			e = s + free_len[i];
			at = align_up(s, al);
			if (at > e || e - at < sz)
				continue;
			if (at > s) begin
				if (at + sz < e) begin
					if (free_total >= RUNS)
						return ffa_pkg::ST_FULL;
					shift_open(i + 1);
					free_start[i + 1] = at + sz;
					free_len[i + 1] = e - (at + sz);
				end
				free_len[i] = at - s;
			end else if (at + sz < e) begin
				free_start[i] = at + sz;
				free_len[i] = e - (at + sz);
			end else begin
				shift_close(i);
			end
			got = at;
			return ffa_pkg::ST_OK;
		end
		return ffa_pkg::ST_NOFIT;
	endfunction

	function automatic logic [1:0] give_back(longint unsigned off, longint unsigned sz);
		int p;
		p = 0;
		if (sz > LIMIT_ADDR - off)
			sz = LIMIT_ADDR - off;
		if (sz == 0)
			return ffa_pkg::ST_OK;
		if (free_total >= RUNS)
			return ffa_pkg::ST_FULL;
		while (p < free_total && free_start[p] < off)
			p++;
		shift_open(p);
		free_start[p] = off;
		free_len[p] = sz;
		if (p + 1 < free_total && free_start[p] + free_len[p] == free_start[p + 1]) begin
			free_len[p] += free_len[p + 1];
			shift_close(p + 1);
		end
		if (p > 0 && free_start[p - 1] + free_len[p - 1] == free_start[p]) begin
			free_len[p - 1] += free_len[p];
			shift_close(p);
		end
		return ffa_pkg::ST_OK;
	endfunction

	// Works out the expected result of one request and queues it.
	function automatic void predict_request(logic [1:0] f, logic [31:0] sz,
			logic [31:0] al, logic [31:0] off);
		alloc_result_t r;
		longint unsigned got;
		r.st = ffa_pkg::ST_OK;
		got = 0;
		if (f == ffa_pkg::FUNC_ALLOC) begin
			r.st = take_run(sz, al, got);
			if (r.st != ffa_pkg::ST_OK)
				got = 0;
		end else if (f == ffa_pkg::FUNC_RELEASE) begin
			r.st = give_back(off, sz);
		end else if (f == ffa_pkg::FUNC_CLEAR) begin
			rebuild_table();
		end
		r.off = got[31:0];
		r.cnt = free_total[6:0];
		pending_results = {pending_results, r};
	endfunction

	// Sends one request, with an optional idle burst ahead of it.
	task automatic send_request(logic [1:0] f, logic [31:0] sz, logic [31:0] al,
			logic [31:0] off);
		if (gaps_on && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 18)) @(negedge clk);
		in_valid <= 1'b1;
		func <= f;
		req_size <= sz;
		req_alignment <= al;
		req_offset <= off;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_request(f, sz, al, off);
		// Valid drops after the handshake while the block works on the request.
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_region(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ffa_pkg::ADDR_REGION;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		region_len = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Sizes mostly small, so runs split and merge often.
	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'd0;
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	function automatic logic [31:0] pick_align();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom();
			2: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	// Release offset near a held run edge, or anywhere.
	function automatic logic [31:0] pick_offset();
		if ($urandom_range(0, 3) == 0 || free_total == 0)
			return $urandom();
		return 32'(free_start[$urandom_range(0, free_total - 1)] -
			longint'($urandom_range(0, 8192)));
	endfunction

	task automatic random_mix(int n);
		logic [1:0] f;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: f = ffa_pkg::FUNC_CLEAR;
				1: f = ffa_pkg::FUNC_NONE;
				2, 3, 4, 5, 6, 7, 8, 9: f = ffa_pkg::FUNC_RELEASE;
				default: f = ffa_pkg::FUNC_ALLOC;
			endcase
			send_request(f, pick_size(), pick_align(), pick_offset());
		end
	endtask

	// Directed edges: extremes of each field, every function, special cases.
	task automatic test_directed();
		send_request(ffa_pkg::FUNC_ALLOC, 0, 0, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 100, 0, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 0, 7, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 50, 3, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 0, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 10, 32'hFFFF_FFFF, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 10, 32'h8000_0000, 0);
		send_request(ffa_pkg::FUNC_RELEASE, 0, 0, 5);
		send_request(ffa_pkg::FUNC_RELEASE, 100, 0, 0);
		send_request(ffa_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
		send_request(ffa_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 0, 32'h4000_0000);
		send_request(ffa_pkg::FUNC_RELEASE, 16, 32'hFFFF_FFFF, 32'h0200_0000);
		send_request(ffa_pkg::FUNC_RELEASE, 4, 0, 32'h0200_0000);
		send_request(ffa_pkg::FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ffa_pkg::FUNC_CLEAR, 0, 0, 0);
		// Fill the table with isolated runs, then probe the full cases.
		for (int i = 0; i < 66; i++)
			send_request(ffa_pkg::FUNC_ALLOC, 8, 16, 0);
		send_request(ffa_pkg::FUNC_RELEASE, 4, 0, 32'h0100_0001);
		send_request(ffa_pkg::FUNC_ALLOC, 3, 5, 0);
		send_request(ffa_pkg::FUNC_CLEAR, 0, 0, 0);
	endtask

	task automatic test_region_settings();
		wait_drained();
		write_region(0);
		send_request(ffa_pkg::FUNC_CLEAR, 0, 0, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 0, 0, 0);
		send_request(ffa_pkg::FUNC_RELEASE, 10, 0, 20);
		wait_drained();
		write_region(32'hFFFF_FFFF);
		send_request(ffa_pkg::FUNC_CLEAR, 0, 0, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 0, 0);
		send_request(ffa_pkg::FUNC_ALLOC, 32'hFFFF_FFFE, 1, 0);
		random_mix(150);
		wait_drained();
		write_region(1);
		send_request(ffa_pkg::FUNC_CLEAR, 0, 0, 0);
		random_mix(80);
		wait_drained();
		write_region(32'h0001_0000);
		send_request(ffa_pkg::FUNC_CLEAR, 0, 0, 0);
	endtask

	// The receiver holds off while requests keep arriving.
	task automatic test_backpressure();
		fork
			begin
				hold_out = 1'b1;
				repeat (400) @(negedge clk);
				hold_out = 1'b0;
			end
			random_mix(30);
		join
	endtask

	task automatic test_random();
		random_mix(800);
		gaps_on = 1'b0;
		random_mix(150);
	endtask

	initial begin
		region_len = ffa_pkg::RESET_REGION;
		rebuild_table();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_region_settings();
		test_backpressure();
		test_random();
		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS first_fit_aligned_free_run_allocator");
		else
			$display("FAIL first_fit_aligned_free_run_allocator");
		$finish;
	end

endmodule
